// ----- hdl/tba_pkg.sv -----
`default_nettype none

package tba_pkg;

   localparam int FIELD_W = 48;
   localparam int ACC_W   = 64;
   localparam int MAG_W   = 49;
   localparam int MU_W    = 78;
   localparam int GIGA_W  = 30;
   localparam int SQ_W    = 98;
   localparam int ROOT_W  = 50;
   localparam int DEN_W   = 148;
   localparam int PROD_W  = 127;
   localparam int QUO_W   = 63;
   localparam int CNT_W   = 7;

   localparam logic [GIGA_W-1:0] GIGA    = 30'd1000000000;
   localparam logic [ACC_W-1:0]  ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0]  ACC_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
   } tba_vec_type;

   typedef struct packed {
      logic [2:0][ACC_W-1:0] term;
      logic                  fault;
   } tba_term_type;

   typedef enum logic [3:0] {
      VU_IDLE,
      VU_SQUARE,
      VU_ROOT,
      VU_DMUL,
      VU_PMUL,
      VU_CHECK,
      VU_DIV,
      VU_STORE,
      VU_DONE
   } tba_vu_state_type;

   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_SCALE,
      TOP_REL_GO,
      TOP_REL_WAIT,
      TOP_SUM_GO,
      TOP_SUM_WAIT,
      TOP_COMBINE,
      TOP_FINISH
   } tba_top_state_type;

   function automatic logic [ACC_W-1:0] sat64(input logic [ACC_W:0] v);
      logic [ACC_W-1:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tba_req_if.sv -----
`default_nettype none

interface tba_req_if import tba_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] craft_x;
   logic signed [FIELD_W-1:0] craft_y;
   logic signed [FIELD_W-1:0] craft_z;
   logic signed [FIELD_W-1:0] rel_x;
   logic signed [FIELD_W-1:0] rel_y;
   logic signed [FIELD_W-1:0] rel_z;
   logic [FIELD_W-1:0]        grav_param;
   logic                      last_body;

   modport source (output valid, craft_x, craft_y, craft_z, rel_x, rel_y, rel_z,
                   grav_param, last_body, input ready);
   modport sink (input valid, craft_x, craft_y, craft_z, rel_x, rel_y, rel_z,
                 grav_param, last_body, output ready);
endinterface

`default_nettype wire

// ----- hdl/tba_rsp_if.sv -----
`default_nettype none

interface tba_rsp_if import tba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] acc_x;
   logic signed [ACC_W-1:0] acc_y;
   logic signed [ACC_W-1:0] acc_z;
   logic                    fault;

   modport source (output valid, acc_x, acc_y, acc_z, fault, input ready);
   modport sink (input valid, acc_x, acc_y, acc_z, fault, output ready);
endinterface

`default_nettype wire

// ----- hdl/tba_vec_unit.sv -----
`default_nettype none

module tba_vec_unit import tba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  tba_vec_type  vec,
   input  logic [MU_W-1:0] mu,
   output logic         busy,
   output logic         done,
   output tba_term_type result
);

   tba_vu_state_type state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             axis_ff, axis_in, axis_nx;
   tba_vec_type            vec_ff, vec_in;
   logic [MU_W-1:0]        mu_ff, mu_in;
   logic [DEN_W-1:0]       mcand_ff, mcand_in;
   logic [ROOT_W-1:0]      mplier_ff, mplier_in;
   logic [SQ_W-1:0]        nsq_ff, nsq_in, sq_sum;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [2:0]             low_ff, low_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [2:0][ACC_W-1:0]  term_ff, term_in;
   logic                   fault_ff, fault_in;
   logic                   too_big;

   assign axis_nx = axis_ff + 2'd1;
   assign sq_sum  = mplier_ff[0] ? nsq_ff + mcand_ff[SQ_W-1:0] : nsq_ff;
   // quotient would reach 2^63 when p >= d * 8
   assign too_big = (DEN_W+3)'(prod_ff) >= {den_ff, 3'b000};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         VU_IDLE:   if (start) state_in = VU_SQUARE;
         VU_SQUARE: if (cnt_ff == '0 && axis_ff == 2'd2) begin
            state_in = (sq_sum == '0) ? VU_DONE : VU_ROOT;
         end
         VU_ROOT:   if (cnt_ff == '0) state_in = VU_DMUL;
         VU_DMUL:   if (cnt_ff == '0) state_in = VU_PMUL;
         VU_PMUL:   if (cnt_ff == '0) state_in = VU_CHECK;
         VU_CHECK:  state_in = too_big ? VU_STORE : VU_DIV;
         VU_DIV:    if (cnt_ff == '0) state_in = VU_STORE;
         VU_STORE:  state_in = (axis_ff == 2'd2) ? VU_DONE : VU_PMUL;
         VU_DONE:   state_in = VU_IDLE;
         default:   state_in = VU_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != VU_IDLE);
      done = (state_ff == VU_DONE);
      result.term  = term_ff;
      result.fault = fault_ff;
   end

   always_comb begin
      logic [52:0]       rem_t;
      logic [52:0]       trial;
      logic [ROOT_W-1:0] root_nx;
      logic [DEN_W:0]    div_t;
      logic              div_ge;
      logic [ACC_W-1:0]  q_ext;

      rem_t     = '0;
      trial     = '0;
      root_nx   = root_ff;
      div_t     = '0;
      div_ge    = 1'b0;
      q_ext     = '0;
      cnt_in    = cnt_ff;
      axis_in   = axis_ff;
      vec_in    = vec_ff;
      mu_in     = mu_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      nsq_in    = nsq_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      term_in   = term_ff;
      fault_in  = fault_ff;

      case (state_ff)
         VU_IDLE: if (start) begin
            vec_in    = vec;
            mu_in     = mu;
            nsq_in    = '0;
            axis_in   = '0;
            cnt_in    = CNT_W'(MAG_W-1);
            mcand_in  = DEN_W'(vec.mag[0]);
            mplier_in = ROOT_W'(vec.mag[0]);
            fault_in  = 1'b0;
         end
         VU_SQUARE: begin
            nsq_in    = sq_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               if (axis_ff == 2'd2) begin
                  if (sq_sum == '0) begin
                     // zero distance: term is zero, flag it
                     term_in  = '0;
                     fault_in = 1'b1;
                  end
                  mcand_in = DEN_W'({2'b00, sq_sum});
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = CNT_W'(ROOT_W-1);
               end else begin
                  axis_in   = axis_nx;
                  mcand_in  = DEN_W'(vec_ff.mag[axis_nx]);
                  mplier_in = ROOT_W'(vec_ff.mag[axis_nx]);
                  cnt_in    = CNT_W'(MAG_W-1);
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         VU_ROOT: begin
            // two radicand bits per step, restoring square root
            rem_t = {rem_ff[50:0], mcand_ff[99:98]};
            trial = {1'b0, root_ff, 2'b01};
            if (rem_t >= trial) begin
               rem_in  = DEN_W'(rem_t - trial);
               root_nx = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = DEN_W'(rem_t);
               root_nx = {root_ff[ROOT_W-2:0], 1'b0};
            end
            root_in  = root_nx;
            mcand_in = mcand_ff << 2;
            if (cnt_ff == '0) begin
               mcand_in  = DEN_W'(nsq_ff);
               mplier_in = root_nx;
               den_in    = '0;
               cnt_in    = CNT_W'(ROOT_W-1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         VU_DMUL: begin
            if (mplier_ff[0]) den_in = den_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               axis_in   = '0;
               prod_in   = '0;
               mcand_in  = DEN_W'(mu_ff);
               mplier_in = ROOT_W'(vec_ff.mag[0]);
               cnt_in    = CNT_W'(MAG_W-1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         VU_PMUL: begin
            if (mplier_ff[0]) prod_in = prod_ff + mcand_ff[PROD_W-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
         end
         VU_CHECK: begin
            if (too_big) begin
               quo_in   = '1;
               fault_in = 1'b1;
            end else begin
               rem_in = DEN_W'(prod_ff[PROD_W-1:3]);
               low_in = prod_ff[2:0];
               quo_in = '0;
               cnt_in = CNT_W'(QUO_W-1);
            end
         end
         VU_DIV: begin
            div_t  = {rem_ff, low_ff[2]};
            div_ge = div_t >= {1'b0, den_ff};
            rem_in = div_ge ? DEN_W'(div_t - {1'b0, den_ff}) : DEN_W'(div_t);
            quo_in = {quo_ff[QUO_W-2:0], div_ge};
            low_in = {low_ff[1:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         VU_STORE: begin
            q_ext = {1'b0, quo_ff};
            term_in[axis_ff] = vec_ff.neg[axis_ff] ? -q_ext : q_ext;
            if (axis_ff != 2'd2) begin
               axis_in   = axis_nx;
               prod_in   = '0;
               mcand_in  = DEN_W'(mu_ff);
               mplier_in = ROOT_W'(vec_ff.mag[axis_nx]);
               cnt_in    = CNT_W'(MAG_W-1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      axis_ff   <= axis_in;
      vec_ff    <= vec_in;
      mu_ff     <= mu_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      nsq_ff    <= nsq_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      prod_ff   <= prod_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      term_ff   <= term_in;
      fault_ff  <= fault_in;
   end

endmodule

`default_nettype wire

// ----- hdl/third_body_gravity_accumulator_unit.sv -----
`default_nettype none

// channel   dir  handshake              payload
// req_chan  in   valid/ready            craft_x/y/z, rel_x/y/z, grav_param, last_body
// rsp_chan  out  valid/ready, reg out   acc_x/y/z, fault (only after last_body)
//
// Each item runs the mu scale, then two passes through the bit-serial unit (squares,
// root, n*r, three products and 63-bit divides), then a combine and a finish step
// before the next accept.
// A zero distance or a saturated term shortens a pass.
// Reset clears the running sum and fault; ready returns only when idle.
// A waiting result does not block the next item; it stalls only when a
// second total is due before the first is taken.

module third_body_gravity_accumulator_unit import tba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tba_req_if.sink   req_chan,
   tba_rsp_if.source rsp_chan
);

   tba_top_state_type state_ff, state_in;
   logic [2:0][FIELD_W-1:0] craft_ff, craft_in;
   logic [2:0][FIELD_W-1:0] rel_ff, rel_in;
   logic                    last_ff, last_in;
   logic [MU_W-1:0]         mu_ff, mu_in, gpsh_ff, gpsh_in;
   logic [GIGA_W-1:0]       giga_ff, giga_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [2:0][ACC_W-1:0]   trel_ff, trel_in;
   logic [2:0][ACC_W-1:0]   ts_ff, ts_in;
   logic                    item_flt_ff, item_flt_in;
   logic [2:0][ACC_W-1:0]   acc_ff, acc_in;
   logic                    fault_seen_ff, fault_seen_in;
   logic [2:0][ACC_W-1:0]   out_ff, out_in;
   logic                    out_fault_ff, out_fault_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic         req_acc;
   logic         can_load;
   logic         vu_start, vu_busy, vu_done;
   tba_vec_type  vu_vec;
   tba_term_type vu_res;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   tba_vec_unit u_vec (
      .clock  (clock),
      .reset  (reset),
      .start  (vu_start),
      .vec    (vu_vec),
      .mu     (mu_ff),
      .busy   (vu_busy),
      .done   (vu_done),
      .result (vu_res)
   );

   // rel on the first pass, s = craft + rel on the second
   always_comb begin
      logic [MAG_W-1:0] c49, r49, v49;
      for (int i = 0; i < 3; i++) begin
         c49 = {craft_ff[i][FIELD_W-1], craft_ff[i]};
         r49 = {rel_ff[i][FIELD_W-1], rel_ff[i]};
         v49 = (state_ff == TOP_SUM_GO) ? c49 + r49 : r49;
         vu_vec.neg[i] = v49[MAG_W-1];
         vu_vec.mag[i] = v49[MAG_W-1] ? -v49 : v49;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE:     if (req_acc) state_in = TOP_SCALE;
         TOP_SCALE:    if (cnt_ff == '0) state_in = TOP_REL_GO;
         TOP_REL_GO:   state_in = TOP_REL_WAIT;
         TOP_REL_WAIT: if (vu_done) state_in = TOP_SUM_GO;
         TOP_SUM_GO:   state_in = TOP_SUM_WAIT;
         TOP_SUM_WAIT: if (vu_done) state_in = TOP_COMBINE;
         TOP_COMBINE:  state_in = TOP_FINISH;
         TOP_FINISH:   if (!last_ff || can_load) state_in = TOP_IDLE;
         default:      state_in = TOP_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == TOP_IDLE);
      vu_start       = (state_ff == TOP_REL_GO) || (state_ff == TOP_SUM_GO);
      rsp_chan.valid = rsp_valid_ff;
      rsp_chan.acc_x = out_ff[0];
      rsp_chan.acc_y = out_ff[1];
      rsp_chan.acc_z = out_ff[2];
      rsp_chan.fault = out_fault_ff;
   end

   always_comb begin
      logic [ACC_W:0]   diff, tot;
      logic [ACC_W-1:0] c;
      logic             ovf;

      diff          = '0;
      tot           = '0;
      c             = '0;
      ovf           = 1'b0;
      craft_in      = craft_ff;
      rel_in        = rel_ff;
      last_in       = last_ff;
      mu_in         = mu_ff;
      gpsh_in       = gpsh_ff;
      giga_in       = giga_ff;
      cnt_in        = cnt_ff;
      trel_in       = trel_ff;
      ts_in         = ts_ff;
      item_flt_in   = item_flt_ff;
      acc_in        = acc_ff;
      fault_seen_in = fault_seen_ff;
      out_in        = out_ff;
      out_fault_in  = out_fault_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         TOP_IDLE: if (req_acc) begin
            craft_in    = {req_chan.craft_z, req_chan.craft_y, req_chan.craft_x};
            rel_in      = {req_chan.rel_z, req_chan.rel_y, req_chan.rel_x};
            last_in     = req_chan.last_body;
            mu_in       = '0;
            gpsh_in     = MU_W'(req_chan.grav_param);
            giga_in     = GIGA;
            cnt_in      = 5'(GIGA_W-1);
            item_flt_in = 1'b0;
         end
         TOP_SCALE: begin
            if (giga_ff[0]) mu_in = mu_ff + gpsh_ff;
            gpsh_in = gpsh_ff << 1;
            giga_in = giga_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
         end
         TOP_REL_WAIT: if (vu_done) begin
            trel_in     = vu_res.term;
            item_flt_in = item_flt_ff | vu_res.fault;
         end
         TOP_SUM_WAIT: if (vu_done) begin
            ts_in       = vu_res.term;
            item_flt_in = item_flt_ff | vu_res.fault;
         end
         TOP_COMBINE: begin
            for (int i = 0; i < 3; i++) begin
               diff = {trel_ff[i][ACC_W-1], trel_ff[i]} - {ts_ff[i][ACC_W-1], ts_ff[i]};
               c    = sat64(diff);
               tot  = {acc_ff[i][ACC_W-1], acc_ff[i]} + {c[ACC_W-1], c};
               acc_in[i] = sat64(tot);
               ovf = ovf | (diff[ACC_W] != diff[ACC_W-1]) | (tot[ACC_W] != tot[ACC_W-1]);
            end
            fault_seen_in = fault_seen_ff | item_flt_ff | ovf;
         end
         TOP_FINISH: if (last_ff && can_load) begin
            out_in        = acc_ff;
            out_fault_in  = fault_seen_ff;
            rsp_valid_in  = 1'b1;
            acc_in        = '0;
            fault_seen_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= TOP_IDLE;
         acc_ff        <= '0;
         fault_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         fault_seen_ff <= fault_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      craft_ff     <= craft_in;
      rel_ff       <= rel_in;
      last_ff      <= last_in;
      mu_ff        <= mu_in;
      gpsh_ff      <= gpsh_in;
      giga_ff      <= giga_in;
      cnt_ff       <= cnt_in;
      trel_ff      <= trel_in;
      ts_ff        <= ts_in;
      item_flt_ff  <= item_flt_in;
      out_ff       <= out_in;
      out_fault_ff <= out_fault_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == TOP_SCALE))
      else $error("accepted item did not start scaling");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == TOP_FINISH && last_ff))
      else $error("result raised without a last body");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      vu_done |-> (vu_busy && (state_ff == TOP_REL_WAIT || state_ff == TOP_SUM_WAIT)))
      else $error("vector unit finished while not awaited");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      vu_done |-> (vu_res.term[0] != ACC_MIN && vu_res.term[1] != ACC_MIN &&
                   vu_res.term[2] != ACC_MIN))
      else $error("point term out of range");

endmodule

`default_nettype wire
